// ----- hdl/bpc_pkg.sv -----
package bpc_pkg;

  // Register stages from the input beat to the output register.
  localparam int NSTAGE = 16;

  // The quotient unit: one quotient bit per stage, starting at stage DIV_FIRST.
  localparam int DIV_STEPS = 8;
  localparam int DIV_FIRST = 7;
  localparam int NUM_W     = 34;
  localparam int DEN_W     = 25;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [16:0] INK_MIN = 17'd128;

  // ceil(2^33 / 255): exact floor division by 255 for any dividend below 2^25.
  localparam logic [25:0] RECIP_255   = 26'd33686019;
  localparam int          RECIP_SHIFT = 33;

  // Alpha lock divides by 255 * 65536 and rounds half up.
  localparam logic [DEN_W-1:0] LOCK_DEN  = 25'd16711680;
  localparam logic [NUM_W-1:0] LOCK_BIAS = 34'd8355840;

  localparam logic [15:0] FULL_COLOR = 16'd65025;

  // Configuration register indexes.
  localparam logic [2:0] REG_SRC_RED     = 3'd0;
  localparam logic [2:0] REG_SRC_GREEN   = 3'd1;
  localparam logic [2:0] REG_SRC_BLUE    = 3'd2;
  localparam logic [2:0] REG_SRC_ALPHA   = 3'd3;
  localparam logic [2:0] REG_BLEND_MODE  = 3'd4;
  localparam logic [2:0] REG_ALPHA_LOCK  = 3'd5;
  localparam logic [2:0] REG_STAMP_ALPHA = 3'd6;

  // Blend mode codes; the codes above erase behave as normal.
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_MULTIPLY = 3'd1;
  localparam logic [2:0] MODE_SCREEN   = 3'd2;
  localparam logic [2:0] MODE_ADD      = 3'd3;
  localparam logic [2:0] MODE_ERASE    = 3'd4;

  // What travels beside the arithmetic once the pixel's outcome is known.
  typedef struct packed {
    logic       use_div;
    logic       written;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } side_t;

endpackage

// ----- hdl/bpc_div.sv -----
module bpc_div
  import bpc_pkg::*;
(
  input  logic                 clk,
  input  logic [DIV_STEPS-1:0] en,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic [7:0]           quo
);

  logic [NUM_W-1:0] rem_q [DIV_STEPS-1];
  logic [DEN_W-1:0] den_q [DIV_STEPS-1];
  logic [7:0]       quo_q [DIV_STEPS];

  // Restoring division, most significant quotient bit first. The caller
  // guarantees the quotient fits in eight bits.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    localparam int SH = DIV_STEPS - 1 - j;

    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [7:0]       quo_in;
    logic [NUM_W-1:0] trial;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = 8'd0;
    end else begin : g_rest
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = {{(NUM_W-DEN_W){1'b0}}, den_in} << SH;
    assign take  = (rem_in >= trial);

    // Earlier steps only set higher bits, so this bit is still clear.
    always_ff @(posedge clk) begin
      if (en[j]) begin
        quo_q[j] <= quo_in | ({7'd0, take} << SH);
      end
    end

    if (j < DIV_STEPS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_q[j] <= take ? (rem_in - trial) : rem_in;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo = quo_q[DIV_STEPS-1];

endmodule

// ----- hdl/brush_pixel_compositor.sv -----
// Brush pixel compositor: blends the brush color onto one RGBA8 destination
// pixel per beat, with normal, multiply, screen, add and erase modes, alpha
// lock, and source-over with a division by the new alpha.
//
// Input stream (s_*): one beat per destination pixel with its tip coverage.
// Output stream (m_*): one beat per input beat, in the same order, carrying
// the resulting pixel and a flag that tells whether it was modified.
// Configuration: cfg_we writes cfg_data into the register named by
// cfg_index; indexes beyond the list are ignored. Write only while no beat is
// in flight.
//
// The datapath is a 16-stage pipeline that takes one beat every cycle while
// s_tready is high; stages 7 to 14 form the divider, one quotient bit per
// stage, ahead of the output register. A stage holds its beat only while it
// and every later stage are full and m_tready is low, so bubbles close up
// and s_tready stays high while any stage is free or m_tready is high. A
// result waiting on a stalled receiver does not block new input.
// Reset empties the pipeline and returns the registers to their defaults
// (black brush color, full brush alpha and stamp alpha, normal mode, no lock).
module brush_pixel_compositor
  import bpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // coverage[16:0], dst_red[24:17], dst_green[32:25], dst_blue[40:33],
  // dst_alpha[48:41], zero fill above
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [31:0] m_tdata,
  // written[0]
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic [7:0]  src_red, src_green, src_blue, src_alpha;
  logic [2:0]  blend_mode;
  logic        alpha_lock;
  logic [16:0] stamp_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_red     <= 8'd0;
      src_green   <= 8'd0;
      src_blue    <= 8'd0;
      src_alpha   <= 8'd255;
      blend_mode  <= MODE_NORMAL;
      alpha_lock  <= 1'b0;
      stamp_alpha <= ONE_Q16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_RED:     src_red     <= cfg_data[7:0];
        REG_SRC_GREEN:   src_green   <= cfg_data[7:0];
        REG_SRC_BLUE:    src_blue    <= cfg_data[7:0];
        REG_SRC_ALPHA:   src_alpha   <= cfg_data[7:0];
        REG_BLEND_MODE:  blend_mode  <= cfg_data[2:0];
        REG_ALPHA_LOCK:  alpha_lock  <= cfg_data[0];
        REG_STAMP_ALPHA: stamp_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2:0][7:0] src_col;
  assign src_col = {src_blue, src_green, src_red};

  // Blended color in units of 1/65025.
  function automatic logic [15:0] mix_color(input logic [7:0] s, input logic [7:0] d,
                                            input logic [15:0] sd, input logic [2:0] mode);
    logic [8:0]  sum;
    logic [16:0] sum255;
    logic [16:0] scr;
    logic [15:0] res;
    sum    = {1'b0, s} + {1'b0, d};
    sum255 = ({8'd0, sum} << 8) - {8'd0, sum};
    scr    = sum255 - {1'b0, sd};
    case (mode)
      MODE_MULTIPLY: res = sd;
      MODE_SCREEN:   res = scr[15:0];
      MODE_ADD:      res = (sum255 > {1'b0, FULL_COLOR}) ? FULL_COLOR : sum255[15:0];
      default:       res = {s, 8'd0} - {8'd0, s};
    endcase
    return res;
  endfunction

  // Q16 value rounded half up to a byte, saturated at 255.
  function automatic logic [7:0] round_q16(input logic [24:0] v);
    logic [25:0] s;
    s = {1'b0, v} + 26'd32768;
    return (s[25:16] > 10'd255) ? 8'd255 : s[23:16];
  endfunction

  // ---------------------------------------------------------------- flow
  logic [NSTAGE-1:0] v;
  logic [NSTAGE-1:0] rdy;

  // A stage may load when some stage at or after it is empty, or the
  // receiver takes the output beat.
  always_comb begin
    for (int k = 0; k < NSTAGE; k++) begin
      rdy[k] = m_tready | (|(~v >> k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= s_tvalid;
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = v[NSTAGE-1];

  // ------------------------------------------------ stage 0: coverage * stamp
  logic [16:0]     cov_in, cov_sat, st_sat;
  logic [33:0]     prod_cs;
  logic [32:0]     p0;
  logic [2:0][7:0] dc0;
  logic [7:0]      da0;

  assign cov_in  = s_tdata[16:0];
  assign cov_sat = (cov_in > ONE_Q16) ? ONE_Q16 : cov_in;
  assign st_sat  = (stamp_alpha > ONE_Q16) ? ONE_Q16 : stamp_alpha;
  assign prod_cs = {17'd0, cov_sat} * {17'd0, st_sat};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p0  <= prod_cs[32:0];
      dc0 <= {s_tdata[40:33], s_tdata[32:25], s_tdata[24:17]};
      da0 <= s_tdata[48:41];
    end
  end

  // ------------------------------------------- stage 1: t * src_alpha + 127
  logic [32:0]     t_sum;
  logic [24:0]     x_prod;
  logic [24:0]     x1;
  logic [2:0][7:0] dc1;
  logic [7:0]      da1;

  assign t_sum  = p0 + 33'd32768;
  assign x_prod = {8'd0, t_sum[32:16]} * {17'd0, src_alpha};

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      x1  <= x_prod + 25'd127;
      dc1 <= dc0;
      da1 <= da0;
    end
  end

  // ------------------------------------------- stage 2: divide by 255
  logic [50:0]     sa_prod;
  logic [16:0]     sa2;
  logic [2:0][7:0] dc2;
  logic [7:0]      da2;

  assign sa_prod = {26'd0, x1} * {25'd0, RECIP_255};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sa2 <= sa_prod[RECIP_SHIFT+16:RECIP_SHIFT];
      dc2 <= dc1;
      da2 <= da1;
    end
  end

  // ------------------------------------------- stage 3: byte products
  logic [16:0]      inv2;
  logic [24:0]      dainv_prod;
  logic [2:0][15:0] sd_n, dda_n;
  logic [16:0]      sa3, inv3;
  logic [23:0]      dainv3;
  logic [2:0][15:0] sd3, dda3;
  logic [2:0][7:0]  dc3;
  logic [7:0]       da3;

  assign inv2       = ONE_Q16 - sa2;
  assign dainv_prod = {17'd0, da2} * {8'd0, inv2};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd_n[i]  = {8'd0, dc2[i]} * {8'd0, src_col[i]};
      dda_n[i] = {8'd0, dc2[i]} * {8'd0, da2};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sa3    <= sa2;
      inv3   <= inv2;
      dainv3 <= dainv_prod[23:0];
      sd3    <= sd_n;
      dda3   <= dda_n;
      dc3    <= dc2;
      da3    <= da2;
    end
  end

  // ------------------------- stage 4: blend, new alpha, outcome of the pixel
  logic [24:0]      a_n;
  logic [2:0][15:0] c_n;
  side_t            side_n;
  logic [15:0]      c4_unused_guard;
  logic [2:0][15:0] c4, dda4;
  logic [16:0]      sa4, inv4;
  logic [24:0]      a4;
  logic [2:0][7:0]  dc4;
  side_t            side_q [4:NSTAGE-2];

  assign a_n = ({8'd0, sa3} << 8) - {8'd0, sa3} + {1'b0, dainv3};
  assign c4_unused_guard = '0;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_n[i] = mix_color(src_col[i], dc3[i], sd3[i], blend_mode) | c4_unused_guard;
    end
    side_n.use_div = 1'b0;
    side_n.written = 1'b0;
    side_n.red     = dc3[0];
    side_n.green   = dc3[1];
    side_n.blue    = dc3[2];
    side_n.alpha   = da3;
    // Faint ink leaves the pixel as it is.
    if (sa3 >= INK_MIN) begin
      if (blend_mode == MODE_ERASE) begin
        side_n.written = 1'b1;
        side_n.alpha   = round_q16({1'b0, dainv3});
      end else if (alpha_lock) begin
        // A transparent pixel stays untouched under alpha lock.
        if (da3 != 8'd0) begin
          side_n.written = 1'b1;
          side_n.use_div = 1'b1;
        end
      end else begin
        side_n.written = 1'b1;
        side_n.use_div = 1'b1;
        side_n.alpha   = round_q16(a_n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      c4   <= c_n;
      dda4 <= dda3;
      sa4  <= sa3;
      inv4 <= inv3;
      a4   <= a_n;
      dc4  <= dc3;
    end
  end

  // ------------------------------------------- stage 5: weighted products
  logic [2:0][32:0] cs_n, ddi_n;
  logic [2:0][24:0] di_n;
  logic [2:0][31:0] cs5, ddi5;
  logic [2:0][23:0] di5;
  logic [24:0]      a5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cs_n[i]  = {17'd0, c4[i]} * {16'd0, sa4};
      ddi_n[i] = {17'd0, dda4[i]} * {16'd0, inv4};
      di_n[i]  = {17'd0, dc4[i]} * {8'd0, inv4};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < 3; i++) begin
        cs5[i]  <= cs_n[i][31:0];
        ddi5[i] <= ddi_n[i][31:0];
        di5[i]  <= di_n[i][23:0];
      end
      a5 <= a4;
    end
  end

  // ------------------------------------------- stage 6: dividend and divisor
  logic [2:0][NUM_W-1:0] n_n;
  logic [DEN_W-1:0]      den_n;
  logic [2:0][NUM_W-1:0] n6;
  logic [DEN_W-1:0]      den6;

  // Rounding half up: lock uses (num + den/2) / den with den = 255 * 65536;
  // source-over uses (2 * num + A) / (2 * A).
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (alpha_lock) begin
        n_n[i] = ({10'd0, di5[i]} << 8) - {10'd0, di5[i]} + {2'd0, cs5[i]} + LOCK_BIAS;
      end else begin
        n_n[i] = (({2'd0, cs5[i]} + {2'd0, ddi5[i]}) << 1) + {9'd0, a5};
      end
    end
    den_n = alpha_lock ? LOCK_DEN : {a5[23:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      n6   <= n_n;
      den6 <= den_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) side_q[4] <= side_n;
    for (int k = 5; k <= NSTAGE - 2; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
  end

  // ------------------------------------------- stages 7 to 14: division
  logic [2:0][7:0] quo;

  for (genvar i = 0; i < 3; i++) begin : g_div
    bpc_div u_div (
      .clk (clk),
      .en  (rdy[DIV_FIRST+DIV_STEPS-1:DIV_FIRST]),
      .num (n6[i]),
      .den (den6),
      .quo (quo[i])
    );
  end

  // ------------------------------------------- stage 15: output register
  side_t side_last;
  assign side_last = side_q[NSTAGE-2];

  always_ff @(posedge clk) begin
    if (rdy[NSTAGE-1]) begin
      m_tdata[7:0]   <= side_last.use_div ? quo[0] : side_last.red;
      m_tdata[15:8]  <= side_last.use_div ? quo[1] : side_last.green;
      m_tdata[23:16] <= side_last.use_div ? quo[2] : side_last.blue;
      m_tdata[31:24] <= side_last.alpha;
      m_tuser        <= side_last.written;
    end
  end

endmodule

// ----- hdl/bpc_checker.sv -----
module bpc_checker
  import bpc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  localparam int PW = $clog2(NSTAGE + 1) + 1;

  // Beats accepted on the input and not yet delivered on the output.
  logic [PW-1:0] pending;
  logic          s_beat, m_beat;

  assign s_beat = s_tvalid & s_tready;
  assign m_beat = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s_beat && !m_beat) begin
      pending <= pending + 1'b1;
    end else if (m_beat && !s_beat) begin
      pending <= pending - 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input blocked while the receiver is ready");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != '0)
    else $error("output beat without an accepted input beat");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= PW'(NSTAGE))
    else $error("more beats in flight than pipeline stages");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind brush_pixel_compositor bpc_checker u_bpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ----- tb/brush_pixel_compositor_tb.sv -----
`timescale 1ns / 1ps

module brush_pixel_compositor_tb;
  import bpc_pkg::*;

  localparam logic [2:0] REG_UNUSED  = 3'd7;
  localparam int         HOLD_CYCLES = 300;
  localparam int         STALL_LIMIT = 3000;
  localparam logic [63:0] LOCK_SCALE = 64'd255 * 64'd65536;

  typedef struct packed {
    logic [7:0]  alpha;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [16:0] coverage;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       written;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // coverage[16:0], dst_red[24:17], dst_green[32:25], dst_blue[40:33],
  // dst_alpha[48:41], zero fill above
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  logic [31:0] m_tdata;
  // written[0]
  logic        m_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  // Local copy of the brush registers, at their reset values.
  logic [7:0]  brush_red = 8'd0;
  logic [7:0]  brush_green = 8'd0;
  logic [7:0]  brush_blue = 8'd0;
  logic [7:0]  brush_alpha = 8'd255;
  logic [2:0]  mode_reg = MODE_NORMAL;
  logic        lock_reg = 1'b0;
  logic [16:0] stamp_reg = ONE_Q16;

  pixel_result_t expected_pixels[$];
  int error_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  brush_pixel_compositor i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] sat_byte(input logic [63:0] v);
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  // Blended channel in units of 1/65025.
  function automatic logic [63:0] blended_color(input logic [63:0] s, input logic [63:0] d,
                                                input logic [2:0] mode);
    logic [63:0] sum;
    sum = 64'd255 * (s + d);
    case (mode)
      MODE_MULTIPLY: return s * d;
      MODE_SCREEN:   return sum - s * d;
      MODE_ADD:      return (sum > FULL_COLOR) ? 64'(FULL_COLOR) : sum;
      default:       return s * 64'd255;
    endcase
  endfunction

  function automatic pixel_result_t composite_pixel(input pixel_in_t px);
    pixel_result_t r;
    logic [63:0] cov, st, t, sa, inv, new_a, num, c, da;
    logic [63:0] dst [3];
    logic [63:0] src [3];
    logic [7:0]  ch [3];
    r = '{red: px.red, green: px.green, blue: px.blue, alpha: px.alpha, written: 1'b0};
    cov = (px.coverage > ONE_Q16) ? 64'(ONE_Q16) : 64'(px.coverage);
    st = (stamp_reg > ONE_Q16) ? 64'(ONE_Q16) : 64'(stamp_reg);
    da = 64'(px.alpha);
    dst[0] = 64'(px.red);
    dst[1] = 64'(px.green);
    dst[2] = 64'(px.blue);
    src[0] = 64'(brush_red);
    src[1] = 64'(brush_green);
    src[2] = 64'(brush_blue);
    t = (cov * st + 64'd32768) >> 16;
    sa = (t * brush_alpha + 64'd127) / 64'd255;
    if (sa < INK_MIN)
      return r;
    inv = 64'(ONE_Q16) - sa;
    r.written = 1'b1;
    if (mode_reg == MODE_ERASE) begin
      r.alpha = sat_byte((da * inv + 64'd32768) >> 16);
      return r;
    end
    if (lock_reg) begin
      // A fully transparent pixel has no color to recolor.
      if (da == 0) begin
        r.written = 1'b0;
        return r;
      end
      for (int i = 0; i < 3; i++) begin
        c = blended_color(src[i], dst[i], mode_reg);
        num = 64'd255 * dst[i] * inv + c * sa;
        ch[i] = sat_byte((num + LOCK_SCALE / 2) / LOCK_SCALE);
      end
    end else begin
      new_a = 64'd255 * sa + da * inv;
      for (int i = 0; i < 3; i++) begin
        c = blended_color(src[i], dst[i], mode_reg);
        num = c * sa + dst[i] * da * inv;
        ch[i] = sat_byte((2 * num + new_a) / (2 * new_a));
      end
      r.alpha = sat_byte((new_a + 64'd32768) >> 16);
    end
    r.red = ch[0];
    r.green = ch[1];
    r.blue = ch[2];
    return r;
  endfunction

  function automatic pixel_in_t make_pixel(input logic [16:0] cov, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b,
                                           input logic [7:0] a);
    return '{alpha: a, blue: b, green: g, red: r, coverage: cov};
  endfunction

  function automatic logic [7:0] random_channel();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_in_t random_pixel();
    logic [16:0] cov;
    case ($urandom_range(9))
      0:       cov = 17'($urandom_range(300));
      1:       cov = ONE_Q16;
      2:       cov = 17'($urandom_range(131071, 65537));
      3:       cov = 17'd0;
      default: cov = 17'($urandom_range(65535));
    endcase
    return make_pixel(cov, random_channel(), random_channel(), random_channel(),
                      random_channel());
  endfunction

  // Byte-wide register value, sometimes with junk in the unused upper bits.
  function automatic logic [16:0] random_byte_reg();
    logic [16:0] v;
    v = {9'($urandom_range(511)), random_channel()};
    if ($urandom_range(1) == 0)
      v[16:8] = '0;
    return v;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      REG_SRC_RED:     brush_red = value[7:0];
      REG_SRC_GREEN:   brush_green = value[7:0];
      REG_SRC_BLUE:    brush_blue = value[7:0];
      REG_SRC_ALPHA:   brush_alpha = value[7:0];
      REG_BLEND_MODE:  mode_reg = value[2:0];
      REG_ALPHA_LOCK:  lock_reg = value[0];
      REG_STAMP_ALPHA: stamp_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Leaves tvalid high after the beat; wait_drained lowers it.
  task automatic send_pixel(input pixel_in_t px);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = {7'd0, px};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_pixels.insert(expected_pixels.size(), composite_pixel(px));
  endtask

  task automatic randomize_brush();
    logic [16:0] stamp;
    logic [2:0]  mode;
    case ($urandom_range(9))
      0:       stamp = 17'd0;
      1:       stamp = 17'($urandom_range(131071, 65537));
      2, 3, 4: stamp = ONE_Q16;
      default: stamp = 17'($urandom_range(65535, 1));
    endcase
    mode = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    write_reg(REG_SRC_RED, random_byte_reg());
    write_reg(REG_SRC_GREEN, random_byte_reg());
    write_reg(REG_SRC_BLUE, random_byte_reg());
    write_reg(REG_SRC_ALPHA, random_byte_reg());
    write_reg(REG_BLEND_MODE, {14'($urandom), mode});
    write_reg(REG_ALPHA_LOCK, {16'($urandom), 1'($urandom_range(1))});
    write_reg(REG_STAMP_ALPHA, stamp);
  endtask

  task automatic test_default_brush();
    send_pixel(make_pixel(17'd0, 8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(make_pixel(ONE_Q16, 8'd255, 8'd0, 8'd128, 8'd255));
    send_pixel(make_pixel(17'h1FFFF, 8'd10, 8'd20, 8'd30, 8'd0));
    send_pixel(make_pixel(17'd32768, 8'd200, 8'd100, 8'd50, 8'd128));
  endtask

  // With full stamp and brush alpha the source alpha equals the coverage.
  task automatic test_ink_threshold();
    send_pixel(make_pixel(INK_MIN - 17'd1, 8'd90, 8'd90, 8'd90, 8'd90));
    send_pixel(make_pixel(INK_MIN, 8'd90, 8'd90, 8'd90, 8'd90));
    write_reg(REG_STAMP_ALPHA, 17'h1FFFF);
    send_pixel(make_pixel(ONE_Q16, 8'd255, 8'd255, 8'd255, 8'd0));
    write_reg(REG_STAMP_ALPHA, 17'd0);
    send_pixel(make_pixel(ONE_Q16, 8'd255, 8'd255, 8'd255, 8'd255));
    write_reg(REG_STAMP_ALPHA, ONE_Q16);
  endtask

  task automatic test_blend_modes();
    logic [2:0] modes [7];
    modes = '{MODE_NORMAL, MODE_MULTIPLY, MODE_SCREEN, MODE_ADD,
              MODE_ERASE + 3'd1, MODE_ERASE + 3'd2, MODE_ERASE + 3'd3};
    write_reg(REG_SRC_RED, 17'd200);
    write_reg(REG_SRC_GREEN, 17'd100);
    write_reg(REG_SRC_BLUE, 17'd30);
    foreach (modes[i]) begin
      write_reg(REG_BLEND_MODE, {14'd0, modes[i]});
      send_pixel(make_pixel(17'd40000, 8'd180, 8'd220, 8'd5, 8'd200));
    end
    write_reg(REG_BLEND_MODE, {14'd0, MODE_NORMAL});
  endtask

  task automatic test_alpha_lock();
    write_reg(REG_ALPHA_LOCK, 17'd1);
    send_pixel(make_pixel(ONE_Q16, 8'd40, 8'd50, 8'd60, 8'd0));
    send_pixel(make_pixel(17'd40000, 8'd10, 8'd250, 8'd128, 8'd128));
    write_reg(REG_BLEND_MODE, {14'd0, MODE_SCREEN});
    send_pixel(make_pixel(ONE_Q16, 8'd255, 8'd0, 8'd77, 8'd255));
  endtask

  // Erase ignores alpha lock, even on a transparent pixel.
  task automatic test_erase();
    write_reg(REG_BLEND_MODE, {14'd0, MODE_ERASE});
    send_pixel(make_pixel(ONE_Q16, 8'd1, 8'd2, 8'd3, 8'd0));
    write_reg(REG_ALPHA_LOCK, 17'd0);
    send_pixel(make_pixel(ONE_Q16, 8'd1, 8'd2, 8'd3, 8'd255));
    send_pixel(make_pixel(17'd30000, 8'd9, 8'd9, 8'd9, 8'd200));
    write_reg(REG_BLEND_MODE, {14'd0, MODE_NORMAL});
  endtask

  task automatic test_unused_index();
    write_reg(REG_UNUSED, 17'h1FFFF);
    write_reg(REG_SRC_RED, 17'h1FF2A);
    send_pixel(make_pixel(17'd50000, 8'd70, 8'd140, 8'd210, 8'd255));
  endtask

  // Each batch ends with the sender waiting for every result before the next brush.
  task automatic test_random_strokes(input int n_pixels);
    int left;
    int batch;
    left = n_pixels;
    while (left > 0) begin
      randomize_brush();
      batch = $urandom_range(30, 8);
      if (batch > left)
        batch = left;
      repeat (batch) send_pixel(random_pixel());
      left -= batch;
    end
    wait_drained();
  endtask

  task automatic test_output_hold();
    randomize_brush();
    write_reg(REG_STAMP_ALPHA, ONE_Q16);
    write_reg(REG_SRC_ALPHA, 17'd255);
    hold_req++;
    repeat (45) send_pixel(random_pixel());
    wait_drained();
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("result beat with no pixel outstanding: tdata %h tuser %b", m_tdata, m_tuser);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_red", want.red, m_tdata[7:0]);
        check_field("out_green", want.green, m_tdata[15:8]);
        check_field("out_blue", want.blue, m_tdata[23:16]);
        check_field("out_alpha", want.alpha, m_tdata[31:24]);
        check_field("written", {7'd0, want.written}, {7'd0, m_tuser});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_gap_pct = 6;
    recv_stall_pct = 60;
    test_default_brush();
    test_ink_threshold();
    test_blend_modes();
    test_alpha_lock();
    test_erase();
    test_unused_index();
    test_random_strokes(130);

    send_gap_pct = 60;
    recv_stall_pct = 6;
    test_random_strokes(130);
    test_output_hold();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_strokes(130);

    repeat (2 * NSTAGE) @(posedge clk);
    if (error_count == 0 && expected_pixels.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
